>>> design/tms_pkg.sv
// shared types and constants for the tone melody sequencer
`default_nettype none

package tms_pkg;

    // field widths
    localparam int CURSOR_W   = 6;
    localparam int TIME_W     = 32;
    localparam int FREQ_W     = 16;
    localparam int DUR_W      = 16;
    localparam int SLOT_W     = 5;
    localparam int COUNT_W    = 8;
    localparam int CMD_W      = 3;
    localparam int ACT_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // register reset values and the minimum note length
    localparam logic [FREQ_W-1:0] CHIRP_FREQ_RST   = 16'd9000;
    localparam logic [DUR_W-1:0]  CHIRP_LENGTH_RST = 16'd12;
    localparam logic [DUR_W-1:0]  CLICK_LENGTH_RST = 16'd6;
    localparam logic [DUR_W-1:0]  MIN_NOTE_LENGTH  = 16'd1;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 3'd0,
        CMD_CHIRP = 3'd1,
        CMD_CLICK = 3'd2,
        CMD_LOAD  = 3'd3,
        CMD_PLAY  = 3'd4,
        CMD_QUIET = 3'd5
    } cmd_t;

    // drive actions
    typedef enum logic [ACT_W-1:0] {
        ACT_NONE    = 2'd0,
        ACT_TONE    = 2'd1,
        ACT_SILENCE = 2'd2
    } act_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLED      = 2'd0,
        CFG_CHIRP_FREQ   = 2'd1,
        CFG_CHIRP_LENGTH = 2'd2,
        CFG_CLICK_LENGTH = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [TIME_W-1:0]  now_ms;
        logic [FREQ_W-1:0]  freq_hz;
        logic [DUR_W-1:0]   dur_ms;
        logic [SLOT_W-1:0]  note_index;
        logic [COUNT_W-1:0] note_count;
        logic               quiet_request;
    } item_t;

    typedef struct packed {
        act_t              drive_action;
        logic [FREQ_W-1:0] tone_freq;
        logic [DUR_W-1:0]  tone_length;
        logic              playing;
        logic              quiet_status;
    } result_t;

    typedef struct packed {
        logic              enabled;
        logic [FREQ_W-1:0] chirp_freq;
        logic [DUR_W-1:0]  chirp_length;
        logic [DUR_W-1:0]  click_length;
    } cfg_regs_t;

    typedef struct packed {
        logic [FREQ_W-1:0] pitch;
        logic [DUR_W-1:0]  length;
    } note_t;

    typedef struct packed {
        logic                wr_en;
        logic [CURSOR_W-1:0] wr_slot;
        note_t               wr_data;
        logic                rd_en;
        logic [CURSOR_W-1:0] rd_slot;
    } store_req_t;

endpackage

`default_nettype wire

>>> design/tms_if.sv
// valid/ready channel interfaces for command, result and configuration beats
`default_nettype none

interface tms_in_if;
    logic                         valid;
    logic                         ready;
    logic [tms_pkg::CMD_W-1:0]    command;
    logic [tms_pkg::TIME_W-1:0]   now_ms;
    logic [tms_pkg::FREQ_W-1:0]   freq_hz;
    logic [tms_pkg::DUR_W-1:0]    dur_ms;
    logic [tms_pkg::SLOT_W-1:0]   note_index;
    logic [tms_pkg::COUNT_W-1:0]  note_count;
    logic                         quiet_request;

    modport source (
        output valid, command, now_ms, freq_hz, dur_ms, note_index, note_count, quiet_request,
        input  ready
    );
    modport sink (
        input  valid, command, now_ms, freq_hz, dur_ms, note_index, note_count, quiet_request,
        output ready
    );
endinterface

interface tms_out_if;
    logic                        valid;
    logic                        ready;
    logic [tms_pkg::ACT_W-1:0]   drive_action;
    logic [tms_pkg::FREQ_W-1:0]  tone_freq;
    logic [tms_pkg::DUR_W-1:0]   tone_length;
    logic                        playing;
    logic                        quiet_status;

    modport source (
        output valid, drive_action, tone_freq, tone_length, playing, quiet_status,
        input  ready
    );
    modport sink (
        input  valid, drive_action, tone_freq, tone_length, playing, quiet_status,
        output ready
    );
endinterface

interface tms_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [tms_pkg::CFG_IDX_W-1:0]   index;
    logic [tms_pkg::CFG_DATA_W-1:0]  data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

`default_nettype wire

>>> design/tone_melody_sequencer_core.sv
// top level of the tone melody sequencer: handshakes, config registers, store and engine
// a command beat is registered in the stage, its result beat in the output register
// throughput: one command per cycle unless the result stalls; the store read for a beat
//   is issued at accept, from the cursor forwarded by the beat ahead of it in the engine
// reset: quiet on, melody idle, deadline and click time zero, config at defaults
// the note store is not cleared; a slot reads as loaded only after a load note
`default_nettype none

module tone_melody_sequencer_core #(
    parameter int MAX_NOTES = 32
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    tms_in_if.sink     item,
    tms_out_if.source  result,
    tms_cfg_if.sink    cfg
);

    localparam int CW = tms_pkg::CURSOR_W;

    tms_pkg::item_t      in_item;
    tms_pkg::item_t      s_item_reg;
    logic                s_valid_reg, s_valid_next;
    logic                s_fire;
    logic                in_fire;
    tms_pkg::result_t    eng_result;
    tms_pkg::result_t    out_reg;
    logic                out_valid_reg, out_valid_next;
    logic [CW-1:0]       cursor_ahead;
    tms_pkg::store_req_t store_req;
    tms_pkg::note_t      note_rd;
    tms_pkg::cfg_regs_t  cfg_regs_reg;

    // gather input beat fields
    always_comb
    begin
        in_item.command       = item.command;
        in_item.now_ms        = item.now_ms;
        in_item.freq_hz       = item.freq_hz;
        in_item.dur_ms        = item.dur_ms;
        in_item.note_index    = item.note_index;
        in_item.note_count    = item.note_count;
        in_item.quiet_request = item.quiet_request;
    end

    // handshakes
    assign s_fire     = s_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !s_valid_reg || s_fire;
    assign in_fire    = item.valid && item.ready;
    assign cfg.ready  = 1'b1;

    // store access at accept: load writes, every beat reads its note
    always_comb
    begin
        store_req.wr_en        = in_fire && (in_item.command == tms_pkg::CMD_LOAD)
                                 && (CW'(in_item.note_index) < CW'(MAX_NOTES));
        store_req.wr_slot      = CW'(in_item.note_index);
        store_req.wr_data.pitch  = in_item.freq_hz;
        store_req.wr_data.length = in_item.dur_ms;
        store_req.rd_en        = in_fire;
        store_req.rd_slot      = (in_item.command == tms_pkg::CMD_PLAY) ? '0
                                                                        : cursor_ahead + CW'(1);
    end

    tms_note_store #(
        .MAX_NOTES (MAX_NOTES)
    ) u_store (
        .clk     (clk),
        .req     (store_req),
        .rd_data (note_rd)
    );

    tms_seq_engine #(
        .MAX_NOTES (MAX_NOTES)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (s_fire),
        .item         (s_item_reg),
        .note         (note_rd),
        .cfg_regs     (cfg_regs_reg),
        .result       (eng_result),
        .cursor_ahead (cursor_ahead)
    );

    // stage and output occupancy
    always_comb
    begin
        s_valid_next = s_valid_reg;
        if (in_fire)
        begin
            s_valid_next = 1'b1;
        end
        else if (s_fire)
        begin
            s_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (s_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s_valid_reg   <= s_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s_item_reg <= in_item;
        end
        if (s_fire)
        begin
            out_reg <= eng_result;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_regs_reg.enabled      <= 1'b0;
            cfg_regs_reg.chirp_freq   <= tms_pkg::CHIRP_FREQ_RST;
            cfg_regs_reg.chirp_length <= tms_pkg::CHIRP_LENGTH_RST;
            cfg_regs_reg.click_length <= tms_pkg::CLICK_LENGTH_RST;
        end
        else if (cfg.valid)
        begin
            unique case (tms_pkg::cfg_idx_t'(cfg.index))
                tms_pkg::CFG_ENABLED:      cfg_regs_reg.enabled      <= cfg.data[0];
                tms_pkg::CFG_CHIRP_FREQ:   cfg_regs_reg.chirp_freq   <= cfg.data;
                tms_pkg::CFG_CHIRP_LENGTH: cfg_regs_reg.chirp_length <= cfg.data;
                tms_pkg::CFG_CLICK_LENGTH: cfg_regs_reg.click_length <= cfg.data;
            endcase
        end
    end

    // result beat
    assign result.valid        = out_valid_reg;
    assign result.drive_action = out_reg.drive_action;
    assign result.tone_freq    = out_reg.tone_freq;
    assign result.tone_length  = out_reg.tone_length;
    assign result.playing      = out_reg.playing;
    assign result.quiet_status = out_reg.quiet_status;

    // a full stage behind a stalled output takes no new beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_valid_reg && out_valid_reg && !result.ready) |-> !item.ready)
        else $error("command accepted while pipeline is full");

    // only a started tone carries pitch and length
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.drive_action != tms_pkg::ACT_TONE))
        |-> (out_reg.tone_freq == '0) && (out_reg.tone_length == '0))
        else $error("tone payload on a non-tone beat");

    // a melody never plays behind the quiet gate
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.playing) |-> !out_reg.quiet_status)
        else $error("melody reported playing while quiet");

endmodule

`default_nettype wire

>>> design/tms_note_store.sv
// note store: one-write one-read synchronous memory of pitch and length per slot
`default_nettype none

module tms_note_store #(
    parameter int MAX_NOTES = 32
) (
    input  wire logic                clk,
    input  wire tms_pkg::store_req_t req,
    output tms_pkg::note_t           rd_data
);

    localparam int AW = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;

    tms_pkg::note_t mem [MAX_NOTES];
    tms_pkg::note_t rd_data_reg;
    logic [AW-1:0]  wr_addr;
    logic [AW-1:0]  rd_addr;

    assign wr_addr = req.wr_slot[AW-1:0];
    assign rd_addr = req.rd_slot[AW-1:0];

    // write port
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[wr_addr] <= req.wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> design/tms_seq_engine.sv
// sequencer engine: melody, click and quiet state with per-command update
`default_nettype none

module tms_seq_engine #(
    parameter int MAX_NOTES = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               fire,
    input  wire tms_pkg::item_t     item,
    input  wire tms_pkg::note_t     note,
    input  wire tms_pkg::cfg_regs_t cfg_regs,
    output tms_pkg::result_t        result,
    output logic [tms_pkg::CURSOR_W-1:0] cursor_ahead
);

    localparam int CW = tms_pkg::CURSOR_W;
    localparam int TW = tms_pkg::TIME_W;
    localparam int NW = tms_pkg::COUNT_W;
    localparam logic [CW-1:0] MAX_LEN = CW'(MAX_NOTES);

    logic          quiet_reg, quiet_next;
    logic          active_reg, active_next;
    logic [CW-1:0] length_reg, length_next;
    logic [CW-1:0] cursor_reg, cursor_next;
    logic [TW-1:0] deadline_reg, deadline_next;
    logic [TW-1:0] last_click_reg, last_click_next;

    logic                          cue_ok;
    logic [TW-1:0]                 deadline_diff;
    logic [TW-1:0]                 click_gap;
    logic [CW-1:0]                 cursor_inc;
    logic [tms_pkg::DUR_W-1:0]     note_len;
    logic                          note_is_tone;
    logic [TW-1:0]                 note_deadline;
    logic [CW-1:0]                 play_len;
    tms_pkg::act_t                 act;
    logic [tms_pkg::FREQ_W-1:0]    act_freq;
    logic [tms_pkg::DUR_W-1:0]     act_len;

    // shared arithmetic
    assign cue_ok        = cfg_regs.enabled && !quiet_reg;
    assign deadline_diff = item.now_ms - deadline_reg;
    assign click_gap     = item.now_ms - last_click_reg;
    assign cursor_inc    = cursor_reg + CW'(1);
    assign note_len      = (note.length == '0) ? tms_pkg::MIN_NOTE_LENGTH : note.length;
    assign note_is_tone  = (note.pitch != '0);
    assign note_deadline = item.now_ms + TW'(note_len);
    assign play_len      = (item.note_count > NW'(MAX_NOTES)) ? MAX_LEN
                                                              : item.note_count[CW-1:0];

    // command decode and next state
    always_comb
    begin
        quiet_next      = quiet_reg;
        active_next     = active_reg;
        length_next     = length_reg;
        cursor_next     = cursor_reg;
        deadline_next   = deadline_reg;
        last_click_next = last_click_reg;
        act             = tms_pkg::ACT_NONE;
        act_freq        = '0;
        act_len         = '0;
        unique case (tms_pkg::cmd_t'(item.command))
            tms_pkg::CMD_TICK:
            begin
                if (active_reg && !deadline_diff[TW-1])
                begin
                    if (cursor_inc >= length_reg)
                    begin
                        active_next   = 1'b0;
                        length_next   = '0;
                        cursor_next   = '0;
                        deadline_next = '0;
                        act           = tms_pkg::ACT_SILENCE;
                    end
                    else
                    begin
                        cursor_next   = cursor_inc;
                        deadline_next = note_deadline;
                        act           = note_is_tone ? tms_pkg::ACT_TONE : tms_pkg::ACT_SILENCE;
                        act_freq      = note.pitch;
                        act_len       = note_is_tone ? note_len : '0;
                    end
                end
            end
            tms_pkg::CMD_CHIRP:
            begin
                if (cue_ok)
                begin
                    active_next   = 1'b0;
                    length_next   = '0;
                    cursor_next   = '0;
                    deadline_next = '0;
                    act           = tms_pkg::ACT_TONE;
                    act_freq      = cfg_regs.chirp_freq;
                    act_len       = cfg_regs.chirp_length;
                end
            end
            tms_pkg::CMD_CLICK:
            begin
                if (cue_ok && (item.freq_hz != '0) && (click_gap >= TW'(cfg_regs.click_length)))
                begin
                    last_click_next = item.now_ms;
                    if (!active_reg)
                    begin
                        act      = tms_pkg::ACT_TONE;
                        act_freq = item.freq_hz;
                        act_len  = cfg_regs.click_length;
                    end
                end
            end
            tms_pkg::CMD_LOAD:
            begin
                // store write happens at accept time
            end
            tms_pkg::CMD_PLAY:
            begin
                if (cue_ok && (item.note_count != '0))
                begin
                    active_next   = 1'b1;
                    length_next   = play_len;
                    cursor_next   = '0;
                    deadline_next = note_deadline;
                    act           = note_is_tone ? tms_pkg::ACT_TONE : tms_pkg::ACT_SILENCE;
                    act_freq      = note.pitch;
                    act_len       = note_is_tone ? note_len : '0;
                end
            end
            tms_pkg::CMD_QUIET:
            begin
                if (item.quiet_request != quiet_reg)
                begin
                    quiet_next = item.quiet_request;
                    if (item.quiet_request)
                    begin
                        active_next   = 1'b0;
                        length_next   = '0;
                        cursor_next   = '0;
                        deadline_next = '0;
                        act           = tms_pkg::ACT_SILENCE;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // result beat contents
    always_comb
    begin
        result.drive_action = act;
        result.tone_freq    = act_freq;
        result.tone_length  = act_len;
        result.playing      = active_next;
        result.quiet_status = quiet_next;
    end

    // cursor seen by the next beat's store read
    assign cursor_ahead = fire ? cursor_next : cursor_reg;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quiet_reg      <= 1'b1;
            active_reg     <= 1'b0;
            length_reg     <= '0;
            cursor_reg     <= '0;
            deadline_reg   <= '0;
            last_click_reg <= '0;
        end
        else if (fire)
        begin
            quiet_reg      <= quiet_next;
            active_reg     <= active_next;
            length_reg     <= length_next;
            cursor_reg     <= cursor_next;
            deadline_reg   <= deadline_next;
            last_click_reg <= last_click_next;
        end
    end

    // idle melody holds cleared cursor and length
    assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> (cursor_reg == '0) && (length_reg == '0))
        else $error("idle melody with stale cursor or length");

    // active melody cursor stays inside its length
    assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (cursor_reg < length_reg) && (length_reg <= MAX_LEN))
        else $error("melody cursor out of range");

    // going quiet always stops the melody
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(quiet_reg) |-> !active_reg)
        else $error("melody still active after going quiet");

endmodule

`default_nettype wire
